/* rtl/core/frjb_pkg.sv */
// shared constants, codes and controller/datapath interface types
package frjb_pkg;

   localparam int PACKETS_PER_FRAME_DEF = 100;
   localparam int FRAME_SLOTS_DEF = 64;

   localparam int SEQ_W = 32;
   localparam int FRAME_W = 26;
   localparam int CFG_W = 7;
   localparam int CSR_IDX_W = 2;
   localparam int OP_W = 2;
   localparam int STATUS_W = 2;
   localparam int FLOW_W = 2;
   localparam int MODE_W = 2;
   localparam int OUT_CNT_W = 7;
   localparam int STEP_W = 2;

   localparam logic [OP_W-1:0] OP_ARRIVAL = 2'd0;
   localparam logic [OP_W-1:0] OP_ASSEMBLE = 2'd1;
   localparam logic [OP_W-1:0] OP_CONSUME = 2'd2;
   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

   localparam logic [STATUS_W-1:0] ST_NONE = 2'd0;
   localparam logic [STATUS_W-1:0] ST_STORED = 2'd1;
   localparam logic [STATUS_W-1:0] ST_DUPLICATE = 2'd2;
   localparam logic [STATUS_W-1:0] ST_CONFLICT = 2'd3;

   localparam logic [FLOW_W-1:0] FLOW_NONE = 2'd0;
   localparam logic [FLOW_W-1:0] FLOW_SLOW = 2'd1;
   localparam logic [FLOW_W-1:0] FLOW_FAST = 2'd2;

   localparam logic [MODE_W-1:0] MODE_FREE = 2'd0;
   localparam logic [MODE_W-1:0] MODE_COLLECT = 2'd1;
   localparam logic [MODE_W-1:0] MODE_READY = 2'd2;

   localparam logic [CSR_IDX_W-1:0] REG_HIGH_WM = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_LOW_WM = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_READY_LIMIT = 2'd2;

   localparam logic [CFG_W-1:0] HIGH_WM_RST = 7'd30;
   localparam logic [CFG_W-1:0] LOW_WM_RST = 7'd5;
   localparam logic [CFG_W-1:0] READY_LIMIT_RST = 7'd40;

   typedef struct packed {
      logic div_load;
      logic div_step;
      logic rd_arr;
      logic arr_exec;
      logic scan_start;
      logic asm_clear;
      logic scan_run;
      logic scan_min;
      logic decide;
      logic pick;
      logic free_elig;
      logic asm_done;
      logic consume;
      logic idle_rsp;
   } cmd_type;

   typedef struct packed {
      logic div_last;
      logic scan_done;
      logic fits;
      logic avail_zero;
      logic round_last;
   } stat_type;

endpackage

/* rtl/core/frjb_ctrl.sv */
// sequencing state machine for arrivals, assemble and consume ticks
module frjb_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [frjb_pkg::OP_W-1:0]     req_operation,
   input  frjb_pkg::stat_type            stat,
   output logic                          busy,
   output frjb_pkg::cmd_type             cmd
);

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_DIV    = 4'd1;
   localparam logic [3:0] S_ARD    = 4'd4;
   localparam logic [3:0] S_AEX    = 4'd5;
   localparam logic [3:0] S_ASCAN  = 4'd6;
   localparam logic [3:0] S_ADEC   = 4'd7;
   localparam logic [3:0] S_MSTART = 4'd8;
   localparam logic [3:0] S_MSCAN  = 4'd9;
   localparam logic [3:0] S_MPICK  = 4'd10;
   localparam logic [3:0] S_AFREE  = 4'd11;
   localparam logic [3:0] S_AFIN   = 4'd12;
   localparam logic [3:0] S_CEXE   = 4'd13;

   logic [3:0] state_ff, state_in;

   assign busy = (state_ff != S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               unique case (req_operation)
                  frjb_pkg::OP_ARRIVAL: begin
                     cmd.div_load = 1'b1;
                     state_in = S_DIV;
                  end
                  frjb_pkg::OP_ASSEMBLE: begin
                     cmd.scan_start = 1'b1;
                     cmd.asm_clear = 1'b1;
                     state_in = S_ASCAN;
                  end
                  frjb_pkg::OP_CONSUME: begin
                     state_in = S_CEXE;
                  end
                  default: begin
                     cmd.idle_rsp = 1'b1;
                  end
               endcase
            end
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (stat.div_last) state_in = S_ARD;
         end
         S_ARD: begin
            cmd.rd_arr = 1'b1;
            state_in = S_AEX;
         end
         S_AEX: begin
            cmd.arr_exec = 1'b1;
            state_in = S_IDLE;
         end
         S_ASCAN: begin
            cmd.scan_run = 1'b1;
            if (stat.scan_done) state_in = S_ADEC;
         end
         S_ADEC: begin
            cmd.decide = 1'b1;
            priority if (stat.fits) state_in = S_AFIN;
            else if (stat.avail_zero) state_in = S_AFREE;
            else state_in = S_MSTART;
         end
         S_MSTART: begin
            cmd.scan_start = 1'b1;
            state_in = S_MSCAN;
         end
         S_MSCAN: begin
            cmd.scan_run = 1'b1;
            cmd.scan_min = 1'b1;
            if (stat.scan_done) state_in = S_MPICK;
         end
         S_MPICK: begin
            cmd.pick = 1'b1;
            state_in = stat.round_last ? S_AFREE : S_MSTART;
         end
         S_AFREE: begin
            cmd.free_elig = 1'b1;
            state_in = S_AFIN;
         end
         S_AFIN: begin
            cmd.asm_done = 1'b1;
            state_in = S_IDLE;
         end
         S_CEXE: begin
            cmd.consume = 1'b1;
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

/* rtl/core/frjb_dp.sv */
// datapath: reciprocal divider, slot memory, slot modes, scan and counters
module frjb_dp #(
   parameter int PACKETS_PER_FRAME = frjb_pkg::PACKETS_PER_FRAME_DEF,
   parameter int FRAME_SLOTS = frjb_pkg::FRAME_SLOTS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  frjb_pkg::cmd_type                   cmd,
   output frjb_pkg::stat_type                  stat,
   input  logic [frjb_pkg::SEQ_W-1:0]          req_seq_number,
   input  logic                                csr_wr_en,
   input  logic [frjb_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [frjb_pkg::CFG_W-1:0]          csr_wr_data,
   output logic                                rsp_strobe,
   output logic [frjb_pkg::STATUS_W-1:0]       rsp_arrival_status,
   output logic [frjb_pkg::OUT_CNT_W-1:0]      rsp_frames_promoted,
   output logic [frjb_pkg::OUT_CNT_W-1:0]      rsp_frames_discarded,
   output logic                                rsp_consumed,
   output logic [frjb_pkg::OUT_CNT_W-1:0]      rsp_remaining_frames,
   output logic [frjb_pkg::FLOW_W-1:0]         rsp_flow_request
);

   localparam int PPF = PACKETS_PER_FRAME;
   localparam int NS = FRAME_SLOTS;
   localparam int FW = frjb_pkg::FRAME_W;
   localparam int SW = frjb_pkg::SEQ_W;
   localparam int SLOT_W = $clog2(NS);
   localparam int IDX_W = $clog2(NS + 1);
   localparam int PKT_W = (PPF > 1) ? $clog2(PPF) : 1;
   localparam int PC_W = $clog2(PPF + 1);
   localparam int BITS_W = PPF;
   localparam int WORD_W = FW + PC_W + BITS_W;
   localparam int AW = ((frjb_pkg::CFG_W > IDX_W) ? frjb_pkg::CFG_W : IDX_W) + 1;

   // reciprocal constants: seq / PPF and frame % NS
   localparam int MW = 17;
   localparam int L1 = $clog2(PPF);
   localparam int K1 = SW + L1;
   localparam longint M1 =
      ((longint'(1) << K1) + longint'(PPF) - longint'(1)) / longint'(PPF);
   localparam logic [MW-1:0] M1_LO = MW'(M1);
   localparam logic [MW-1:0] M1_HI = MW'(M1 >> MW);
   localparam int P1_W = SW + 2 * MW;
   localparam int L2 = $clog2(NS);
   localparam int K2 = FW + L2;
   localparam int M2_W = FW + 2;
   localparam longint M2 =
      ((longint'(1) << K2) + longint'(NS) - longint'(1)) / longint'(NS);
   localparam int P2_W = FW + M2_W;

   logic [frjb_pkg::CFG_W-1:0] high_ff, low_ff, limit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         high_ff <= frjb_pkg::HIGH_WM_RST;
         low_ff <= frjb_pkg::LOW_WM_RST;
         limit_ff <= frjb_pkg::READY_LIMIT_RST;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            frjb_pkg::REG_HIGH_WM: high_ff <= csr_wr_data;
            frjb_pkg::REG_LOW_WM: low_ff <= csr_wr_data;
            frjb_pkg::REG_READY_LIMIT: limit_ff <= csr_wr_data;
            default: ;
         endcase
      end
   end

   // divide by reciprocal multiplication over four steps
   logic [SW-1:0] num_ff;
   logic [frjb_pkg::STEP_W-1:0] step_ff;
   logic [SW+MW-1:0] plo_ff;
   logic [SW-1:0] quo_ff;
   logic [P2_W-1:0] p2_ff;
   logic [FW-1:0] frame_ff;
   logic [PKT_W-1:0] pkt_ff;
   logic [SLOT_W-1:0] slot_ff;
   logic [SLOT_W-1:0] slot;
   logic [SW+MW-1:0] phi;
   logic [P1_W-1:0] acc1;
   logic [SW-1:0] pkt_full;
   logic [FW-1:0] quo2;

   assign phi = (SW+MW)'(num_ff) * (SW+MW)'(M1_HI);
   assign acc1 = P1_W'(plo_ff) + {phi, MW'(0)};
   assign pkt_full = num_ff - quo_ff * SW'(PPF);
   assign quo2 = FW'(p2_ff >> K2);
   assign slot = slot_ff;

   always_ff @(posedge clock) begin
      if (cmd.div_load) begin
         num_ff <= req_seq_number;
         step_ff <= '0;
      end else if (cmd.div_step) begin
         step_ff <= step_ff + frjb_pkg::STEP_W'(1);
         unique case (step_ff)
            2'd0: plo_ff <= (SW+MW)'(num_ff) * (SW+MW)'(M1_LO);
            2'd1: quo_ff <= SW'(acc1 >> K1);
            2'd2: begin
               frame_ff <= quo_ff[FW-1:0];
               pkt_ff <= pkt_full[PKT_W-1:0];
               p2_ff <= P2_W'(quo_ff[FW-1:0]) * P2_W'(M2);
            end
            default: slot_ff <= SLOT_W'(frame_ff - quo2 * FW'(NS));
         endcase
      end
   end

   assign stat.div_last = (step_ff == frjb_pkg::STEP_W'(3));

   // slot memory: frame tag, packet count, packet bitmap
   logic [WORD_W-1:0] mem [NS];
   logic [WORD_W-1:0] mem_q_ff;
   logic [SLOT_W-1:0] rd_addr;
   logic mem_we;
   logic [WORD_W-1:0] mem_wd;
   logic [FW-1:0] q_tag;
   logic [PC_W-1:0] q_cnt;
   logic [BITS_W-1:0] q_bits;

   assign q_tag = mem_q_ff[WORD_W-1 -: FW];
   assign q_cnt = mem_q_ff[BITS_W +: PC_W];
   assign q_bits = mem_q_ff[BITS_W-1:0];

   always_ff @(posedge clock) begin
      if (mem_we) mem[slot] <= mem_wd;
      mem_q_ff <= mem[rd_addr];
   end

   // scan over slots
   logic [IDX_W-1:0] idx_ff;
   logic [SLOT_W-1:0] rd_idx_ff;
   logic rd_vld_ff;
   logic idx_end;
   logic [FW-1:0] cur_ff;
   logic [SLOT_W-1:0] cur_slot_ff;

   assign idx_end = (idx_ff == IDX_W'(NS));
   assign stat.scan_done = idx_end && !rd_vld_ff;

   always_comb begin
      priority if (cmd.scan_run && !idx_end) rd_addr = idx_ff[SLOT_W-1:0];
      else if (cmd.rd_arr) rd_addr = slot;
      else rd_addr = cur_slot_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
         rd_vld_ff <= 1'b0;
      end else if (cmd.scan_start) begin
         idx_ff <= '0;
         rd_vld_ff <= 1'b0;
      end else if (cmd.scan_run) begin
         rd_vld_ff <= !idx_end;
         rd_idx_ff <= idx_ff[SLOT_W-1:0];
         if (!idx_end) idx_ff <= idx_ff + IDX_W'(1);
      end
   end

   // slot modes and eligibility
   logic [frjb_pkg::MODE_W-1:0] mode_ff [NS];
   logic [frjb_pkg::MODE_W-1:0] mode_in [NS];
   logic [NS-1:0] elig_ff, elig_in;
   logic [frjb_pkg::MODE_W-1:0] rd_mode, arr_mode, cur_mode;
   logic complete, older, scan_a, scan_m;
   logic [FW-1:0] best_tag_ff;
   logic [SLOT_W-1:0] best_idx_ff;
   logic best_found_ff;
   logic better;
   logic hit;

   assign rd_mode = mode_ff[rd_idx_ff];
   assign arr_mode = mode_ff[slot];
   assign cur_mode = mode_ff[cur_slot_ff];
   assign complete = (rd_mode == frjb_pkg::MODE_COLLECT) && (q_cnt >= PC_W'(PPF));
   assign older = (q_tag < cur_ff);
   assign scan_a = cmd.scan_run && rd_vld_ff && !cmd.scan_min;
   assign scan_m = cmd.scan_run && rd_vld_ff && cmd.scan_min;
   assign better = elig_ff[rd_idx_ff] && (!best_found_ff || (q_tag < best_tag_ff));
   assign hit = (cur_mode == frjb_pkg::MODE_READY) && (q_tag == cur_ff);

   always_comb begin
      mode_in = mode_ff;
      elig_in = elig_ff;
      if (scan_a && complete) begin
         if (older) mode_in[rd_idx_ff] = frjb_pkg::MODE_FREE;
         else elig_in[rd_idx_ff] = 1'b1;
      end
      if (cmd.decide && stat.fits) begin
         for (int i = 0; i < NS; i++) begin
            if (elig_ff[i]) mode_in[i] = frjb_pkg::MODE_READY;
         end
         elig_in = '0;
      end
      if (cmd.pick) begin
         mode_in[best_idx_ff] = frjb_pkg::MODE_READY;
         elig_in[best_idx_ff] = 1'b0;
      end
      if (cmd.free_elig) begin
         for (int i = 0; i < NS; i++) begin
            if (elig_ff[i]) mode_in[i] = frjb_pkg::MODE_FREE;
         end
         elig_in = '0;
      end
      if (cmd.arr_exec && arr_mode == frjb_pkg::MODE_FREE) begin
         mode_in[slot] = frjb_pkg::MODE_COLLECT;
      end
      if (cmd.consume && hit) mode_in[cur_slot_ff] = frjb_pkg::MODE_FREE;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NS; i++) mode_ff[i] <= frjb_pkg::MODE_FREE;
         elig_ff <= '0;
      end else begin
         mode_ff <= mode_in;
         elig_ff <= elig_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.scan_start) begin
         best_found_ff <= 1'b0;
      end else if (scan_m && better) begin
         best_found_ff <= 1'b1;
         best_tag_ff <= q_tag;
         best_idx_ff <= rd_idx_ff;
      end
   end

   // arrival update
   logic [BITS_W-1:0] one_hot;
   logic [frjb_pkg::STATUS_W-1:0] arr_status;

   assign one_hot = BITS_W'(1) << pkt_ff;

   always_comb begin
      mem_we = 1'b0;
      mem_wd = {q_tag, q_cnt + PC_W'(1), q_bits | one_hot};
      priority if (arr_mode == frjb_pkg::MODE_FREE) begin
         arr_status = frjb_pkg::ST_STORED;
         mem_we = cmd.arr_exec;
         mem_wd = {frame_ff, PC_W'(1), one_hot};
      end else if (q_tag != frame_ff) begin
         arr_status = frjb_pkg::ST_CONFLICT;
      end else if (arr_mode == frjb_pkg::MODE_READY) begin
         arr_status = frjb_pkg::ST_DUPLICATE;
      end else if (|(q_bits & one_hot)) begin
         arr_status = frjb_pkg::ST_DUPLICATE;
      end else begin
         arr_status = frjb_pkg::ST_STORED;
         mem_we = cmd.arr_exec;
      end
   end

   // assemble counters
   logic [IDX_W-1:0] n_ff, disc_ff, prom_ff, rounds_ff, rc_ff;
   logic [AW-1:0] avail, n_ext;

   assign avail = (AW'(limit_ff) > AW'(rc_ff)) ? (AW'(limit_ff) - AW'(rc_ff)) : '0;
   assign n_ext = AW'(n_ff);
   assign stat.fits = (n_ext <= avail);
   assign stat.avail_zero = (avail == '0);
   assign stat.round_last = (rounds_ff == IDX_W'(1));

   // consume
   logic [IDX_W-1:0] rc_next;
   logic [FW-1:0] cur_next;

   assign rc_next = (hit && rc_ff != '0) ? (rc_ff - IDX_W'(1)) : rc_ff;
   assign cur_next = cur_ff + FW'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         rc_ff <= '0;
         cur_ff <= '0;
         cur_slot_ff <= '0;
      end else begin
         if (cmd.decide) begin
            if (stat.fits) rc_ff <= rc_ff + n_ff;
            else rc_ff <= rc_ff + IDX_W'(avail);
         end
         if (cmd.consume) begin
            rc_ff <= rc_next;
            cur_ff <= cur_next;
            if (cur_next == '0 || cur_slot_ff == SLOT_W'(NS - 1)) cur_slot_ff <= '0;
            else cur_slot_ff <= cur_slot_ff + SLOT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.asm_clear) begin
         n_ff <= '0;
         disc_ff <= '0;
      end else if (scan_a && complete) begin
         if (older) disc_ff <= disc_ff + IDX_W'(1);
         else n_ff <= n_ff + IDX_W'(1);
      end else if (cmd.decide) begin
         if (stat.fits) begin
            prom_ff <= n_ff;
         end else begin
            prom_ff <= IDX_W'(avail);
            disc_ff <= disc_ff + n_ff - IDX_W'(avail);
            rounds_ff <= IDX_W'(avail);
         end
      end else if (cmd.pick) begin
         rounds_ff <= rounds_ff - IDX_W'(1);
      end
   end

   // result registers
   logic [AW-1:0] rem_ext;
   logic [frjb_pkg::FLOW_W-1:0] flow;

   assign rem_ext = AW'(rc_next);

   always_comb begin
      priority if (rem_ext > AW'(high_ff)) flow = frjb_pkg::FLOW_SLOW;
      else if (rem_ext < AW'(low_ff)) flow = frjb_pkg::FLOW_FAST;
      else flow = frjb_pkg::FLOW_NONE;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe <= 1'b0;
      end else begin
         rsp_strobe <= cmd.arr_exec || cmd.asm_done || cmd.consume || cmd.idle_rsp;
      end
   end

   always_ff @(posedge clock) begin
      rsp_arrival_status <= cmd.arr_exec ? arr_status : frjb_pkg::ST_NONE;
      rsp_frames_promoted <= cmd.asm_done ? frjb_pkg::OUT_CNT_W'(prom_ff) : '0;
      rsp_frames_discarded <= cmd.asm_done ? frjb_pkg::OUT_CNT_W'(disc_ff) : '0;
      rsp_consumed <= cmd.consume && hit;
      rsp_remaining_frames <= cmd.consume ? frjb_pkg::OUT_CNT_W'(rc_next) : '0;
      rsp_flow_request <= cmd.consume ? flow : frjb_pkg::FLOW_NONE;
   end

endmodule

/* rtl/core/frame_reassembly_jitter_buffer_core.sv */
// Jitter buffer top level. A transaction is taken when start is high and busy is low; each
// transaction yields exactly one result, shown for one cycle with rsp_strobe high, and the
// receiver cannot stall it. A packet arrival keeps busy high while reciprocal
// multiplication steps give the frame, packet and slot numbers, then the slot memory
// is read and written. An assemble tick scans the slots through the single memory
// read port, then, when the ready limit forces a choice among complete frames, rescans
// once per promoted frame to pick the oldest eligible one, then finishes. A consume tick
// is done in the S_CEXE state; an unknown operation is answered without raising busy. The
// result strobe is registered and comes with busy low. Slot memory needs no clearing pass after reset.
module frame_reassembly_jitter_buffer_core #(
   parameter int PACKETS_PER_FRAME = frjb_pkg::PACKETS_PER_FRAME_DEF,
   parameter int FRAME_SLOTS = frjb_pkg::FRAME_SLOTS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [frjb_pkg::OP_W-1:0]           req_operation,
   input  logic [frjb_pkg::SEQ_W-1:0]          req_seq_number,
   input  logic                                csr_wr_en,
   input  logic [frjb_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [frjb_pkg::CFG_W-1:0]          csr_wr_data,
   output logic                                rsp_strobe,
   output logic [frjb_pkg::STATUS_W-1:0]       rsp_arrival_status,
   output logic [frjb_pkg::OUT_CNT_W-1:0]      rsp_frames_promoted,
   output logic [frjb_pkg::OUT_CNT_W-1:0]      rsp_frames_discarded,
   output logic                                rsp_consumed,
   output logic [frjb_pkg::OUT_CNT_W-1:0]      rsp_remaining_frames,
   output logic [frjb_pkg::FLOW_W-1:0]         rsp_flow_request
);

   frjb_pkg::cmd_type cmd;
   frjb_pkg::stat_type stat;

   frjb_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .req_operation (req_operation),
      .stat          (stat),
      .busy          (busy),
      .cmd           (cmd)
   );

   frjb_dp #(
      .PACKETS_PER_FRAME (PACKETS_PER_FRAME),
      .FRAME_SLOTS       (FRAME_SLOTS)
   ) u_dp (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .stat                 (stat),
      .req_seq_number       (req_seq_number),
      .csr_wr_en            (csr_wr_en),
      .csr_index            (csr_index),
      .csr_wr_data          (csr_wr_data),
      .rsp_strobe           (rsp_strobe),
      .rsp_arrival_status   (rsp_arrival_status),
      .rsp_frames_promoted  (rsp_frames_promoted),
      .rsp_frames_discarded (rsp_frames_discarded),
      .rsp_consumed         (rsp_consumed),
      .rsp_remaining_frames (rsp_remaining_frames),
      .rsp_flow_request     (rsp_flow_request)
   );

endmodule
